[rtl/mf3_pkg.sv]
`timescale 1ns / 1ps

package mf3_pkg;

   // Line length the design is built for
   localparam int MAX_LINE_PIXELS_DEF = 1024;

   // Field widths
   localparam int CHAN_W         = 8;
   localparam int CHANNELS       = 3;
   localparam int WIN_TAPS       = 9;
   localparam int IMG_WIDTH_W    = 11;
   localparam int IMG_HEIGHT_W   = 13;
   localparam int ROW_W          = 12;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 13;

   // Row limit of a frame
   localparam int MAX_ROWS       = 4096;

   // Smallest window extent on either axis
   localparam int MIN_EXTENT     = 3;

   // Reset sizes
   localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = IMG_WIDTH_W'(640);
   localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = IMG_HEIGHT_W'(480);

   // Result queue
   localparam int QUEUE_DEPTH    = 8;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = QUEUE_PTR_W + 1;

   // Colour lane positions inside a pixel
   localparam int CH_RED         = 0;
   localparam int CH_GREEN       = 1;
   localparam int CH_BLUE        = 2;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } mf3_csr_type;

   typedef logic [CHANNELS-1:0][CHAN_W-1:0] mf3_pixel_type;

   typedef struct packed {
      logic              frame_start;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } mf3_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] median_red;
      logic [CHAN_W-1:0] median_green;
      logic [CHAN_W-1:0] median_blue;
      logic              last_of_frame;
   } mf3_rsp_type;

   // Result strobe from the lanes towards the queue
   typedef struct packed {
      logic valid;
      logic last;
   } mf3_push_type;

endpackage

[rtl/mf3_line_store.sv]
`timescale 1ns / 1ps

module mf3_line_store
   import mf3_pkg::*;
#(
   parameter int  DEPTH  = MAX_LINE_PIXELS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  mf3_pixel_type       wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output mf3_pixel_type       rd_data
);

   mf3_pixel_type mem [DEPTH];
   mf3_pixel_type rd_data_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-edge collision
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mf3_median_lane.sv]
`timescale 1ns / 1ps

module mf3_median_lane
   import mf3_pkg::*;
(
   input  logic                              clock,
   input  logic [WIN_TAPS-1:0][CHAN_W-1:0]   taps,
   output logic [CHAN_W-1:0]                 median
);

   logic [WIN_TAPS-1:0][CHAN_W-1:0] a_in, a_ff;
   logic [WIN_TAPS-1:0][CHAN_W-1:0] b_in, b_ff;
   logic [WIN_TAPS-1:0][CHAN_W-1:0] c_in;
   logic [CHAN_W-1:0]               median_ff;

   // Compare-exchange: {low, high}
   function automatic logic [2*CHAN_W-1:0] sort2(input logic [CHAN_W-1:0] x,
                                                input logic [CHAN_W-1:0] y);
      return (x > y) ? {y, x} : {x, y};
   endfunction

   // Stage A: sort each group of three
   always_comb begin
      a_in = taps;
      {a_in[1], a_in[2]} = sort2(a_in[1], a_in[2]);
      {a_in[4], a_in[5]} = sort2(a_in[4], a_in[5]);
      {a_in[7], a_in[8]} = sort2(a_in[7], a_in[8]);
      {a_in[0], a_in[1]} = sort2(a_in[0], a_in[1]);
      {a_in[3], a_in[4]} = sort2(a_in[3], a_in[4]);
      {a_in[6], a_in[7]} = sort2(a_in[6], a_in[7]);
      {a_in[1], a_in[2]} = sort2(a_in[1], a_in[2]);
      {a_in[4], a_in[5]} = sort2(a_in[4], a_in[5]);
      {a_in[7], a_in[8]} = sort2(a_in[7], a_in[8]);
   end

   // Stage B: max of mins, min of maxes, sort of mids
   always_comb begin
      b_in = a_ff;
      {b_in[0], b_in[3]} = sort2(b_in[0], b_in[3]);
      {b_in[5], b_in[8]} = sort2(b_in[5], b_in[8]);
      {b_in[4], b_in[7]} = sort2(b_in[4], b_in[7]);
      {b_in[3], b_in[6]} = sort2(b_in[3], b_in[6]);
      {b_in[1], b_in[4]} = sort2(b_in[1], b_in[4]);
      {b_in[2], b_in[5]} = sort2(b_in[2], b_in[5]);
      {b_in[4], b_in[7]} = sort2(b_in[4], b_in[7]);
   end

   // Stage C: median of the three survivors
   always_comb begin
      c_in = b_ff;
      {c_in[4], c_in[2]} = sort2(c_in[4], c_in[2]);
      {c_in[6], c_in[4]} = sort2(c_in[6], c_in[4]);
      {c_in[4], c_in[2]} = sort2(c_in[4], c_in[2]);
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      median_ff <= c_in[4];
   end

   assign median = median_ff;

endmodule

[rtl/mf3_out_queue.sv]
`timescale 1ns / 1ps

module mf3_out_queue
   import mf3_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  mf3_push_type                      push,
   input  logic [CHANNELS-1:0][CHAN_W-1:0]   medians,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mf3_rsp_type                       rsp_data,
   output logic [QUEUE_CNT_W-1:0]            count
);

   mf3_rsp_type                 q_ff [QUEUE_DEPTH];
   mf3_rsp_type                 word_in;
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                        pop;

   // Merge the three lane medians into one result word
   always_comb begin
      word_in.median_red    = medians[CH_RED];
      word_in.median_green  = medians[CH_GREEN];
      word_in.median_blue   = medians[CH_BLUE];
      word_in.last_of_frame = push.last;
   end

   assign pop = rsp_valid && !rsp_stall;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         q_ff[wr_ptr_ff] <= word_in;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

[rtl/median_filter_3x3_rgb_unit.sv]
`timescale 1ns / 1ps

// 3x3 median filter over an RGB pixel stream in raster order.
// req_ channel: one pixel word per accepted cycle; frame_start marks the
// first pixel of a frame and returns the position to row 0, column 0.
// rsp_ channel: one word per interior pixel, the per-colour median of its
// 3x3 neighbourhood, issued when the pixel below-right of the centre is
// taken; last_of_frame flags the result of the frame's final pixel.
// Border pixels give no word. csr_ port writes image width (index 0) and
// height (index 1); csr_ready is always high. Change them only when idle.
// Throughput: one pixel per cycle while req_stall is low, set by the line
// stores (separate read and write ports, each used once per pixel) and the
// fully pipelined lanes. A result passes the stage 1 registers (line store
// read), three sorting stages and the result queue before it reaches rsp_.
// Stall: an eight-word queue holds results; req_stall rises once queued
// plus in-flight results would fill it, so nothing is lost.
// Reset: position and window clear, sizes return to 640 x 480, the queue
// empties. Line stores are not cleared; no clearing pass is needed.
module median_filter_3x3_rgb_unit
   import mf3_pkg::*;
#(
   parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mf3_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mf3_rsp_type              rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
   localparam int WCMP_W = (COL_W + 1 > IMG_WIDTH_W) ? COL_W + 1 : IMG_WIDTH_W;
   localparam int LAT    = 3;

   logic                        accept;
   logic [IMG_WIDTH_W-1:0]      width_ff, width_in;
   logic [IMG_HEIGHT_W-1:0]     height_ff, height_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [WCMP_W-1:0]           w_eff;
   logic [IMG_HEIGHT_W-1:0]     h_eff;
   logic [COL_W-1:0]            c_cur;
   logic [ROW_W-1:0]            r_cur;
   logic                        row_end, frame_end, has_res;
   mf3_pixel_type               pix_cur;

   // Stage 1 registers (line store data arrives alongside)
   logic                        s1_valid_ff, s1_res_ff, s1_fwd_ff;
   logic                        s1_last_ff;
   logic [COL_W-1:0]            s1_addr_ff;
   mf3_pixel_type               s1_pix_ff, s1_fwd_up_ff, s1_fwd_mid_ff;
   logic                        s1_fwd_in;

   mf3_pixel_type               upper_rd, middle_rd, up_s1, mid_s1;
   mf3_pixel_type               win_ff [6];
   mf3_pixel_type               taps_px [WIN_TAPS];
   logic [CHANNELS-1:0][WIN_TAPS-1:0][CHAN_W-1:0] lane_taps;
   logic [CHANNELS-1:0][CHAN_W-1:0]               medians;

   logic [LAT-1:0]              res_pipe_ff, last_pipe_ff;
   logic [2:0]                  pending;
   logic [QUEUE_CNT_W-1:0]      q_count;
   logic [QUEUE_CNT_W:0]        credit_sum;
   mf3_push_type                push;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data[IMG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_data[IMG_HEIGHT_W-1:0];
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // Effective sizes, saturated to the supported range
   always_comb begin
      w_eff = WCMP_W'(width_ff);
      if (w_eff < WCMP_W'(MIN_EXTENT)) begin
         w_eff = WCMP_W'(MIN_EXTENT);
      end else if (w_eff > WCMP_W'(MAX_LINE_PIXELS)) begin
         w_eff = WCMP_W'(MAX_LINE_PIXELS);
      end
      h_eff = height_ff;
      if (h_eff < IMG_HEIGHT_W'(MIN_EXTENT)) begin
         h_eff = IMG_HEIGHT_W'(MIN_EXTENT);
      end else if (h_eff > IMG_HEIGHT_W'(MAX_ROWS)) begin
         h_eff = IMG_HEIGHT_W'(MAX_ROWS);
      end
   end

   // Position of the incoming pixel and its end-of-row / frame flags
   always_comb begin
      c_cur     = req_data.frame_start ? '0 : col_ff;
      r_cur     = req_data.frame_start ? '0 : row_ff;
      row_end   = (WCMP_W'(c_cur) + WCMP_W'(1)) >= w_eff;
      frame_end = row_end &&
                  ((IMG_HEIGHT_W'(r_cur) + IMG_HEIGHT_W'(1)) >= h_eff);
      has_res   = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
      pix_cur[CH_RED]   = req_data.red_in;
      pix_cur[CH_GREEN] = req_data.green_in;
      pix_cur[CH_BLUE]  = req_data.blue_in;
   end

   // Next position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = r_cur + 1'b1;
         end else begin
            col_in = c_cur + 1'b1;
            row_in = r_cur;
         end
      end
   end

   // Same address as the write now in stage 1: bypass the store
   assign s1_fwd_in = s1_valid_ff && (s1_addr_ff == c_cur);

   assign up_s1  = s1_fwd_ff ? s1_fwd_up_ff  : upper_rd;
   assign mid_s1 = s1_fwd_ff ? s1_fwd_mid_ff : middle_rd;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s1_res_ff    <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         res_pipe_ff  <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= accept;
         s1_res_ff    <= accept && has_res;
         s1_fwd_ff    <= accept && s1_fwd_in;
         res_pipe_ff  <= {res_pipe_ff[LAT-2:0], s1_res_ff};
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff    <= c_cur;
         s1_pix_ff     <= pix_cur;
         s1_last_ff    <= frame_end;
         s1_fwd_up_ff  <= mid_s1;
         s1_fwd_mid_ff <= s1_pix_ff;
      end
      last_pipe_ff <= {last_pipe_ff[LAT-2:0], s1_last_ff};
   end

   // Window columns c-2 and c-1, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_s1;
         win_ff[4] <= mid_s1;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // Line stores: rows r-2 and r-1
   mf3_line_store #(
      .DEPTH   (MAX_LINE_PIXELS)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (mid_s1),
      .rd_addr (c_cur),
      .rd_data (upper_rd)
   );

   mf3_line_store #(
      .DEPTH   (MAX_LINE_PIXELS)
   ) u_middle_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff),
      .rd_addr (c_cur),
      .rd_data (middle_rd)
   );

   // 3x3 neighbourhood: top, middle, bottom rows of columns c-2, c-1, c
   always_comb begin
      taps_px[0] = win_ff[0];
      taps_px[1] = win_ff[3];
      taps_px[2] = up_s1;
      taps_px[3] = win_ff[1];
      taps_px[4] = win_ff[4];
      taps_px[5] = mid_s1;
      taps_px[6] = win_ff[2];
      taps_px[7] = win_ff[5];
      taps_px[8] = s1_pix_ff;
      for (int k = 0; k < CHANNELS; k++) begin
         for (int i = 0; i < WIN_TAPS; i++) begin
            lane_taps[k][i] = taps_px[i][k];
         end
      end
   end

   // One median lane per colour
   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      mf3_median_lane u_lane (
         .clock  (clock),
         .taps   (lane_taps[k]),
         .median (medians[k])
      );
   end

   assign push.valid = res_pipe_ff[LAT-1];
   assign push.last  = last_pipe_ff[LAT-1];

   mf3_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .medians   (medians),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

   // Credit: queued plus in-flight results must fit the queue
   assign pending    = 3'(s1_res_ff) + 3'(res_pipe_ff[0]) + 3'(res_pipe_ff[1]) +
                       3'(res_pipe_ff[2]);
   assign credit_sum = (QUEUE_CNT_W + 1)'(q_count) + (QUEUE_CNT_W + 1)'(pending);
   assign req_stall  = credit_sum >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);

`ifndef SYNTH
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_sum <= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH))
      else $error("result queue credit exceeded");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("position not cleared after last pixel of frame");

   a_push_origin: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> $past(accept, 4))
      else $error("result pushed without a matching accepted pixel");
`endif

endmodule
